>>> rtl/ffp_pkg.sv
// Package for the first-fit layer slot packer: sizes, record types and
// the sequencer state encoding. It depends on nothing else.
package ffp_pkg;

  localparam int HALF_SLOTS     = 4096;
  localparam int RES_BITS       = $clog2(HALF_SLOTS);
  localparam int MAX_LAYERS     = 256;
  localparam int LAYER_BITS     = $clog2(MAX_LAYERS);
  localparam int COUNT_BITS     = $clog2(MAX_LAYERS + 1);
  localparam int BLOCK_BITS     = 16;
  localparam int POS_BITS       = 28;
  localparam int TAG_BITS       = 16;
  localparam int LIMIT_BITS     = 17;
  localparam int SLOT_BITS      = RES_BITS + 1;
  localparam int SLOT_ADDR_BITS = LAYER_BITS + RES_BITS;
  localparam int SLOT_DEPTH     = MAX_LAYERS * HALF_SLOTS;
  localparam int EPOCH_BITS     = 6;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(2);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_PLACE
  } state_t;

  typedef struct packed {
    logic bot;
    logic top;
  } pair_t;

  typedef struct packed {
    logic [BLOCK_BITS-1:0] lo;
    logic [BLOCK_BITS-1:0] hi;
  } range_t;

  typedef struct packed {
    logic                      en;
    logic [SLOT_ADDR_BITS-1:0] addr;
    pair_t                     pair;
  } slot_wr_t;

  typedef struct packed {
    logic                  en;
    logic [LAYER_BITS-1:0] addr;
    range_t                rng;
  } range_wr_t;

  typedef struct packed {
    range_t rng;
    logic   fits;
  } span_res_t;

endpackage

>>> rtl/ffp_span_unit.sv
// Shared span unit: widens a layer's block range to take one block and
// checks the inclusive span against the limit. Depends on ffp_pkg.
module ffp_span_unit (
  input  ffp_pkg::range_t                  cur,
  input  logic [ffp_pkg::BLOCK_BITS-1:0]   blk,
  input  logic [ffp_pkg::LIMIT_BITS-1:0]   limit,
  output ffp_pkg::span_res_t               res
);

  logic [ffp_pkg::BLOCK_BITS-1:0] lo;
  logic [ffp_pkg::BLOCK_BITS-1:0] hi;
  logic [ffp_pkg::LIMIT_BITS-1:0] span;

  always_comb begin
    lo   = (cur.lo < blk) ? cur.lo : blk;
    hi   = (cur.hi > blk) ? cur.hi : blk;
    span = ffp_pkg::LIMIT_BITS'(hi) - ffp_pkg::LIMIT_BITS'(lo) + ffp_pkg::LIMIT_BITS'(1);
    res.rng.lo = lo;
    res.rng.hi = hi;
    res.fits   = (span <= limit);
  end

endmodule

>>> rtl/ffp_slot_store.sv
// Slot pair memory: top/bottom used bits per layer and residue, each entry
// marked with the set epoch that wrote it. Depends on ffp_pkg.
module ffp_slot_store (
  input  logic                                clk,
  input  ffp_pkg::slot_wr_t                   wr,
  input  logic [ffp_pkg::EPOCH_BITS-1:0]      cur_epoch,
  input  logic [ffp_pkg::SLOT_ADDR_BITS-1:0]  rd_addr,
  output ffp_pkg::pair_t                      rd_pair
);

  typedef struct packed {
    logic [ffp_pkg::EPOCH_BITS-1:0] epoch;
    ffp_pkg::pair_t                 pair;
  } slot_ent_t;

  slot_ent_t mem [ffp_pkg::SLOT_DEPTH];
  slot_ent_t rd_ent_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= '{epoch: cur_epoch, pair: wr.pair};
    end
    rd_ent_r <= mem[rd_addr];
  end

  // An entry written in an earlier set reads as both slots free.
  assign rd_pair = (rd_ent_r.epoch == cur_epoch) ? rd_ent_r.pair : '0;

endmodule

>>> rtl/ffp_range_store.sv
// Block range memory: lowest and highest block of each layer, with a
// registered read port. Depends on ffp_pkg.
module ffp_range_store (
  input  logic                             clk,
  input  ffp_pkg::range_wr_t               wr,
  input  logic [ffp_pkg::LAYER_BITS-1:0]   rd_addr,
  output ffp_pkg::range_t                  rd_rng
);

  ffp_pkg::range_t mem [ffp_pkg::MAX_LAYERS];
  ffp_pkg::range_t rd_rng_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.rng;
    end
    rd_rng_r <= mem[rd_addr];
  end

  assign rd_rng = rd_rng_r;

endmodule

>>> rtl/first_fit_layer_slot_packer.sv
// A transaction is placed in the first open layer that takes it; if none does, it opens a new
// layer, or it overflows when every layer is already open.
// Transactions are taken one at a time: the next one is accepted in the idle state after the result is
// registered; the layer search reads one layer a cycle from the range and slot memories.
// Reset and every 64th set end in a clearing pass over all 1048576 entries of the slot memory.
// Reset is synchronous and active low; span_limit resets to 2.
module first_fit_layer_slot_packer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ffp_pkg::LIMIT_BITS-1:0]       cfg_span_limit,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ffp_pkg::TAG_BITS-1:0]         in_item_tag,
  input  logic [ffp_pkg::POS_BITS-1:0]         in_position,
  input  logic                                 in_last_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ffp_pkg::TAG_BITS-1:0]         out_tag_out,
  output logic [ffp_pkg::LAYER_BITS-1:0]       out_layer_index,
  output logic [ffp_pkg::SLOT_BITS-1:0]        out_slot_index,
  output logic [ffp_pkg::BLOCK_BITS-1:0]       out_block_index,
  output logic                                 out_opened_layer,
  output logic                                 out_overflow,
  output logic [ffp_pkg::COUNT_BITS-1:0]       out_layers_used,
  output logic                                 out_set_done
);

  ffp_pkg::state_t                      state_r, state_nxt;
  logic [ffp_pkg::LIMIT_BITS-1:0]       span_limit_r, span_limit_nxt;
  logic [ffp_pkg::COUNT_BITS-1:0]       count_r, count_nxt;
  logic [ffp_pkg::EPOCH_BITS-1:0]       epoch_r, epoch_nxt;
  logic [ffp_pkg::SLOT_ADDR_BITS-1:0]   clr_addr_r, clr_addr_nxt;
  logic                                 eval_vld_r, eval_vld_nxt;
  logic                                 out_valid_r, out_valid_nxt;

  logic [ffp_pkg::TAG_BITS-1:0]         tag_r, tag_nxt;
  logic [ffp_pkg::RES_BITS-1:0]         res_r, res_nxt;
  logic [ffp_pkg::BLOCK_BITS-1:0]       blk_r, blk_nxt;
  logic                                 last_r, last_nxt;
  logic [ffp_pkg::COUNT_BITS-1:0]       issue_r, issue_nxt;
  logic [ffp_pkg::LAYER_BITS-1:0]       eval_idx_r, eval_idx_nxt;
  logic [ffp_pkg::LAYER_BITS-1:0]       place_layer_r, place_layer_nxt;
  ffp_pkg::range_t                      place_rng_r, place_rng_nxt;
  ffp_pkg::pair_t                       place_pair_r, place_pair_nxt;
  logic                                 place_bot_r, place_bot_nxt;
  logic                                 opened_r, opened_nxt;
  logic                                 ovf_r, ovf_nxt;

  logic [ffp_pkg::TAG_BITS-1:0]         o_tag_r, o_tag_nxt;
  logic [ffp_pkg::LAYER_BITS-1:0]       o_layer_r, o_layer_nxt;
  logic [ffp_pkg::SLOT_BITS-1:0]        o_slot_r, o_slot_nxt;
  logic [ffp_pkg::BLOCK_BITS-1:0]       o_blk_r, o_blk_nxt;
  logic                                 o_opened_r, o_opened_nxt;
  logic                                 o_ovf_r, o_ovf_nxt;
  logic [ffp_pkg::COUNT_BITS-1:0]       o_used_r, o_used_nxt;
  logic                                 o_done_r, o_done_nxt;

  ffp_pkg::slot_wr_t                    slot_wr;
  ffp_pkg::range_wr_t                   range_wr;
  ffp_pkg::pair_t                       rd_pair;
  ffp_pkg::range_t                      rd_rng;
  ffp_pkg::span_res_t                   span;
  logic [ffp_pkg::SLOT_ADDR_BITS-1:0]   slot_rd_addr;
  logic [ffp_pkg::COUNT_BITS-1:0]       used_after;
  logic                                 issue_more;
  logic                                 hit;
  logic                                 out_free;
  logic                                 full;

  assign slot_rd_addr = {issue_r[ffp_pkg::LAYER_BITS-1:0], res_r};

  ffp_range_store u_range (
    .clk     (clk),
    .wr      (range_wr),
    .rd_addr (issue_r[ffp_pkg::LAYER_BITS-1:0]),
    .rd_rng  (rd_rng)
  );

  ffp_slot_store u_slot (
    .clk       (clk),
    .wr        (slot_wr),
    .cur_epoch (epoch_r),
    .rd_addr   (slot_rd_addr),
    .rd_pair   (rd_pair)
  );

  ffp_span_unit u_span (
    .cur   (rd_rng),
    .blk   (blk_r),
    .limit (span_limit_r),
    .res   (span)
  );

  assign issue_more = (issue_r < count_r);
  assign hit        = eval_vld_r && !(rd_pair.top && rd_pair.bot) && span.fits;
  assign out_free   = !out_valid_r || out_ready;
  assign full       = (count_r == ffp_pkg::COUNT_BITS'(ffp_pkg::MAX_LAYERS));
  assign used_after = count_r + ffp_pkg::COUNT_BITS'(opened_r);

  always_comb begin
    state_nxt       = state_r;
    span_limit_nxt  = span_limit_r;
    count_nxt       = count_r;
    epoch_nxt       = epoch_r;
    clr_addr_nxt    = clr_addr_r;
    eval_vld_nxt    = 1'b0;
    out_valid_nxt   = out_valid_r && !out_ready;
    tag_nxt         = tag_r;
    res_nxt         = res_r;
    blk_nxt         = blk_r;
    last_nxt        = last_r;
    issue_nxt       = issue_r;
    eval_idx_nxt    = eval_idx_r;
    place_layer_nxt = place_layer_r;
    place_rng_nxt   = place_rng_r;
    place_pair_nxt  = place_pair_r;
    place_bot_nxt   = place_bot_r;
    opened_nxt      = opened_r;
    ovf_nxt         = ovf_r;
    o_tag_nxt       = o_tag_r;
    o_layer_nxt     = o_layer_r;
    o_slot_nxt      = o_slot_r;
    o_blk_nxt       = o_blk_r;
    o_opened_nxt    = o_opened_r;
    o_ovf_nxt       = o_ovf_r;
    o_used_nxt      = o_used_r;
    o_done_nxt      = o_done_r;
    in_ready        = 1'b0;
    slot_wr         = '0;
    range_wr        = '0;

    if (cfg_valid) begin
      span_limit_nxt = cfg_span_limit;
    end

    unique case (state_r)
      ffp_pkg::ST_CLEAR: begin
        slot_wr.en   = 1'b1;
        slot_wr.addr = clr_addr_r;
        clr_addr_nxt = clr_addr_r + ffp_pkg::SLOT_ADDR_BITS'(1);
        if (clr_addr_r == '1) begin
          state_nxt = ffp_pkg::ST_IDLE;
        end
      end

      ffp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          tag_nxt   = in_item_tag;
          res_nxt   = in_position[ffp_pkg::RES_BITS-1:0];
          blk_nxt   = in_position[ffp_pkg::RES_BITS +: ffp_pkg::BLOCK_BITS];
          last_nxt  = in_last_item;
          issue_nxt = '0;
          state_nxt = ffp_pkg::ST_SEARCH;
        end
      end

      ffp_pkg::ST_SEARCH: begin
        // Reads of layer i are issued while layer i-1 is being judged.
        if (hit) begin
          place_layer_nxt = eval_idx_r;
          place_rng_nxt   = span.rng;
          place_pair_nxt  = '{bot: rd_pair.bot | rd_pair.top, top: 1'b1};
          place_bot_nxt   = rd_pair.top;
          opened_nxt      = 1'b0;
          ovf_nxt         = 1'b0;
          state_nxt       = ffp_pkg::ST_PLACE;
        end else if (!issue_more) begin
          place_layer_nxt = count_r[ffp_pkg::LAYER_BITS-1:0];
          place_rng_nxt   = '{lo: blk_r, hi: blk_r};
          place_pair_nxt  = '{bot: 1'b0, top: 1'b1};
          place_bot_nxt   = 1'b0;
          opened_nxt      = !full;
          ovf_nxt         = full;
          state_nxt       = ffp_pkg::ST_PLACE;
        end else begin
          eval_vld_nxt = 1'b1;
          eval_idx_nxt = issue_r[ffp_pkg::LAYER_BITS-1:0];
          issue_nxt    = issue_r + ffp_pkg::COUNT_BITS'(1);
        end
      end

      ffp_pkg::ST_PLACE: begin
        // The writes repeat harmlessly while the result register is still full.
        slot_wr.en    = !ovf_r;
        slot_wr.addr  = {place_layer_r, res_r};
        slot_wr.pair  = place_pair_r;
        range_wr.en   = !ovf_r;
        range_wr.addr = place_layer_r;
        range_wr.rng  = place_rng_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_tag_nxt     = tag_r;
          o_layer_nxt   = ovf_r ? '0 : place_layer_r;
          o_slot_nxt    = ovf_r ? '0 : {place_bot_r, res_r};
          o_blk_nxt     = blk_r;
          o_opened_nxt  = opened_r;
          o_ovf_nxt     = ovf_r;
          o_used_nxt    = used_after;
          o_done_nxt    = last_r;
          if (last_r) begin
            count_nxt = '0;
            epoch_nxt = epoch_r + ffp_pkg::EPOCH_BITS'(1);
            // Once the epoch wraps, stale entries could match again, so sweep.
            if (epoch_r == '1) begin
              clr_addr_nxt = '0;
              state_nxt    = ffp_pkg::ST_CLEAR;
            end else begin
              state_nxt = ffp_pkg::ST_IDLE;
            end
          end else begin
            count_nxt = used_after;
            state_nxt = ffp_pkg::ST_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ffp_pkg::ST_CLEAR;
      span_limit_r <= ffp_pkg::LIMIT_RESET;
      count_r      <= '0;
      epoch_r      <= '0;
      clr_addr_r   <= '0;
      eval_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      span_limit_r <= span_limit_nxt;
      count_r      <= count_nxt;
      epoch_r      <= epoch_nxt;
      clr_addr_r   <= clr_addr_nxt;
      eval_vld_r   <= eval_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r         <= tag_nxt;
    res_r         <= res_nxt;
    blk_r         <= blk_nxt;
    last_r        <= last_nxt;
    issue_r       <= issue_nxt;
    eval_idx_r    <= eval_idx_nxt;
    place_layer_r <= place_layer_nxt;
    place_rng_r   <= place_rng_nxt;
    place_pair_r  <= place_pair_nxt;
    place_bot_r   <= place_bot_nxt;
    opened_r      <= opened_nxt;
    ovf_r         <= ovf_nxt;
    o_tag_r       <= o_tag_nxt;
    o_layer_r     <= o_layer_nxt;
    o_slot_r      <= o_slot_nxt;
    o_blk_r       <= o_blk_nxt;
    o_opened_r    <= o_opened_nxt;
    o_ovf_r       <= o_ovf_nxt;
    o_used_r      <= o_used_nxt;
    o_done_r      <= o_done_nxt;
  end

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_tag_out      = o_tag_r;
  assign out_layer_index  = o_layer_r;
  assign out_slot_index   = o_slot_r;
  assign out_block_index  = o_blk_r;
  assign out_opened_layer = o_opened_r;
  assign out_overflow     = o_ovf_r;
  assign out_layers_used  = o_used_r;
  assign out_set_done     = o_done_r;

endmodule

>>> rtl/ffp_checker.sv
// Port-level checks for the first-fit layer slot packer and the bind that
// attaches them to the top level. Depends on ffp_pkg.
module ffp_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [ffp_pkg::TAG_BITS-1:0]       out_tag_out,
  input logic [ffp_pkg::LAYER_BITS-1:0]     out_layer_index,
  input logic [ffp_pkg::SLOT_BITS-1:0]      out_slot_index,
  input logic                               out_opened_layer,
  input logic                               out_overflow,
  input logic [ffp_pkg::COUNT_BITS-1:0]     out_layers_used
);

  // A stalled result transaction keeps its tag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tag_out))
    else $error("result changed while stalled");

  // An overflow places nothing and only happens with every layer open.
  a_ovf_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> !out_opened_layer && out_layer_index == '0 &&
      out_slot_index == '0 &&
      out_layers_used == ffp_pkg::COUNT_BITS'(ffp_pkg::MAX_LAYERS))
    else $error("overflow result is not empty");

  // A freshly opened layer is always the newest one.
  a_open_newest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_opened_layer |->
      out_layers_used == ffp_pkg::COUNT_BITS'(out_layer_index) + ffp_pkg::COUNT_BITS'(1))
    else $error("opened layer is not the last open layer");

  // Any placement lands in a layer that is open.
  a_layer_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overflow |->
      ffp_pkg::COUNT_BITS'(out_layer_index) < out_layers_used)
    else $error("placement in a layer that is not open");

endmodule

bind first_fit_layer_slot_packer ffp_checker u_ffp_checker (.*);
